// ===== sv/rgree_pkg.sv =====
// ----------------------------------------------------------------------------
// rgree_pkg
// Shared types and constants of the polymer Rg / end-to-end accumulator.
// ----------------------------------------------------------------------------
package rgree_pkg;

  localparam int COORD_W  = 24;
  localparam int CNT_W    = 17;
  localparam int SUM_W    = 40;
  localparam int SQS_W    = 64;
  localparam int TOT_W    = 64;
  localparam int MEAN_W   = 48;
  localparam int ROOT_W   = 24;
  localparam int MASK_W   = 3;
  localparam int SQ_IN_W  = 25;
  localparam int SQ_OUT_W = 50;
  localparam int NUM_W    = 82;
  localparam int OPB_W    = 64;
  localparam int REM_W    = 34;
  localparam int DIVS_W   = 33;
  localparam int STEP_W   = 7;
  localparam int REE_W    = 51;

  localparam logic [CNT_W-1:0]  MAX_CHAIN_ATOMS = CNT_W'(65536);
  localparam logic [CNT_W-1:0]  MAX_CHAINS      = CNT_W'(65536);
  localparam logic [MASK_W-1:0] MASK_RESET      = 3'd7;
  localparam logic [MEAN_W-1:0] MEAN_MAX        = {MEAN_W{1'b1}};

  localparam logic [STEP_W-1:0] MUL_LAST  = 7'd63;
  localparam logic [STEP_W-1:0] DIV_LAST  = 7'd81;
  localparam logic [STEP_W-1:0] SQRT_LAST = 7'd23;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } ser_op_e;

  typedef struct packed {
    logic    start;
    ser_op_e op;
  } ser_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ATOM,
    ST_REE,
    ST_NSQ,
    ST_NSQW,
    ST_AXIS,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV_RG,
    ST_CLOSE,
    ST_DIV_MRG,
    ST_DIV_MREE,
    ST_SQ_RG,
    ST_SQ_REE,
    ST_OUT
  } state_e;

endpackage

// ===== sv/rgree_in_if.sv =====
// ----------------------------------------------------------------------------
// rgree_in_if
// Atom word channel: valid/ready with one atom position and end marks.
// ----------------------------------------------------------------------------
interface rgree_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rgree_pkg::COORD_W-1:0] pos_x;
  logic signed [rgree_pkg::COORD_W-1:0] pos_y;
  logic signed [rgree_pkg::COORD_W-1:0] pos_z;
  logic                                 chain_end;
  logic                                 frm_end;

  modport source (output valid, pos_x, pos_y, pos_z, chain_end, frm_end, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, chain_end, frm_end, output ready);
endinterface

// ===== sv/rgree_out_if.sv =====
// ----------------------------------------------------------------------------
// rgree_out_if
// Frame result channel: valid/ready with chain count, means and roots.
// ----------------------------------------------------------------------------
interface rgree_out_if;
  logic                          valid;
  logic                          ready;
  logic [rgree_pkg::CNT_W-1:0]   chain_total;
  logic [rgree_pkg::MEAN_W-1:0]  mean_rg_sq;
  logic [rgree_pkg::ROOT_W-1:0]  mean_rg;
  logic [rgree_pkg::MEAN_W-1:0]  mean_e2e_sq;
  logic [rgree_pkg::ROOT_W-1:0]  mean_e2e;

  modport source (output valid, chain_total, mean_rg_sq, mean_rg, mean_e2e_sq, mean_e2e,
                  input ready);
  modport sink   (input valid, chain_total, mean_rg_sq, mean_rg, mean_e2e_sq, mean_e2e,
                  output ready);
endinterface

// ===== sv/rgree_sq.sv =====
// ----------------------------------------------------------------------------
// rgree_sq
// Registered 25x25 unsigned squarer shared by atom, distance and count paths.
// ----------------------------------------------------------------------------
module rgree_sq (
  input  logic                              clk_i,
  input  logic [rgree_pkg::SQ_IN_W-1:0]     a_i,
  output logic [rgree_pkg::SQ_OUT_W-1:0]    p_o
);

  logic [rgree_pkg::SQ_OUT_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= rgree_pkg::SQ_OUT_W'(a_i) * rgree_pkg::SQ_OUT_W'(a_i);
  end

  assign p_o = p_q;

endmodule

// ===== sv/rgree_ser.sv =====
// ----------------------------------------------------------------------------
// rgree_ser
// Bit-serial shift/add/subtract unit: multiply (64 steps), restoring divide
// (82 steps) and floor square root (24 steps).
// ----------------------------------------------------------------------------
module rgree_ser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rgree_pkg::ser_req_t             req_i,
  input  logic [rgree_pkg::NUM_W-1:0]     a_i,
  input  logic [rgree_pkg::OPB_W-1:0]     b_i,
  output logic                            done_o,
  output logic [rgree_pkg::NUM_W-1:0]     res_o
);

  logic                              busy_q, done_q;
  logic [rgree_pkg::STEP_W-1:0]      cnt_q;
  logic [rgree_pkg::STEP_W-1:0]      last;
  rgree_pkg::ser_op_e                op_q;
  logic [rgree_pkg::NUM_W-1:0]       x_q, x_d, y_q, y_d;
  logic [rgree_pkg::OPB_W-1:0]       b_q, b_d;
  logic [rgree_pkg::REM_W-1:0]       r_q, r_d;
  logic                              load;
  logic [rgree_pkg::REM_W-1:0]       dsh;
  logic                              dge;
  logic [27:0]                       rem, trial, sdiff;
  logic                              sge;

  assign load = req_i.start && !busy_q && !done_q;

  always_comb begin
    case (op_q)
      rgree_pkg::OP_MUL:  last = rgree_pkg::MUL_LAST;
      rgree_pkg::OP_DIV:  last = rgree_pkg::DIV_LAST;
      rgree_pkg::OP_SQRT: last = rgree_pkg::SQRT_LAST;
      default:            last = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= rgree_pkg::OP_MUL;
    end else if (load) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= req_i.op;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 7'd1;
      if (cnt_q == last) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // one step of the selected operation
  always_comb begin
    dsh   = {r_q[rgree_pkg::REM_W-2:0], x_q[rgree_pkg::NUM_W-1]};
    dge   = dsh >= {1'b0, b_q[rgree_pkg::DIVS_W-1:0]};
    rem   = {r_q[25:0], x_q[47:46]};
    trial = {2'b00, b_q[23:0], 2'b01};
    sge   = rem >= trial;
    sdiff = rem - trial;
    x_d   = x_q;
    y_d   = y_q;
    b_d   = b_q;
    r_d   = r_q;
    case (op_q)
      rgree_pkg::OP_MUL: begin
        x_d = b_q[0] ? x_q + y_q : x_q;
        y_d = {y_q[rgree_pkg::NUM_W-2:0], 1'b0};
        b_d = {1'b0, b_q[rgree_pkg::OPB_W-1:1]};
      end
      rgree_pkg::OP_DIV: begin
        r_d = dge ? dsh - {1'b0, b_q[rgree_pkg::DIVS_W-1:0]} : dsh;
        x_d = {x_q[rgree_pkg::NUM_W-2:0], dge};
      end
      rgree_pkg::OP_SQRT: begin
        r_d = {8'b0, sge ? sdiff[25:0] : rem[25:0]};
        x_d = {x_q[rgree_pkg::NUM_W-3:0], 2'b00};
        b_d = {b_q[rgree_pkg::OPB_W-2:0], sge};
      end
      default: begin
        x_d = x_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q <= (req_i.op == rgree_pkg::OP_MUL) ? '0 : a_i;
      y_q <= a_i;
      b_q <= (req_i.op == rgree_pkg::OP_SQRT) ? '0 : b_i;
      r_q <= '0;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      b_q <= b_d;
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == rgree_pkg::OP_SQRT) ?
                  rgree_pkg::NUM_W'(b_q[rgree_pkg::ROOT_W-1:0]) : x_q;

endmodule

// ===== sv/polymer_rg_ree_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// polymer_rg_ree_accumulator_top
// Per-chain Rg^2 and end-to-end^2 accumulation with frame means and roots.
// ----------------------------------------------------------------------------
// channel  dir  word
// in_i     in   pos_x/y/z (s24, 12 frac), chain_end, frm_end
// out_o    out  chain_total, mean_rg_sq, mean_rg, mean_e2e_sq, mean_e2e
// cfg      in   cfg_we_i / cfg_wdata_i -> axis_mask
//
// An atom is accepted in ST_IDLE, then its axes pass through the shared squarer in ST_ATOM.
// A chain end runs the bit-serial unit for two 64-step multiplies per enabled axis
// and one 82-step divide.
// A frame end adds two divides and two square roots in the bit-serial unit.
// in_i.ready is low while a word is in work; a held result blocks only the
// next frame end. Reset clears all sums, counts and the mask to 7.
// ----------------------------------------------------------------------------
module polymer_rg_ree_accumulator_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rgree_pkg::MASK_W-1:0]     cfg_wdata_i,
  rgree_in_if.sink                         in_i,
  rgree_out_if.source                      out_o
);

  localparam int CW = rgree_pkg::COORD_W;

  rgree_pkg::state_e state_q, state_d;

  logic [1:0]                        ax_q;
  logic [1:0]                        axs, axp;
  logic [rgree_pkg::MASK_W-1:0]      mask_q;
  logic signed [CW-1:0]              p_q     [3];
  logic signed [CW-1:0]              first_q [3];
  logic signed [rgree_pkg::SUM_W-1:0] csum_q [3];
  logic [rgree_pkg::SQS_W-1:0]       ssum_q  [3];
  logic [rgree_pkg::CNT_W-1:0]       cnt_q, cc_q;
  logic [rgree_pkg::TOT_W-1:0]       rgt_q, reet_q;
  logic                              ce_q, fe_q, add_q;
  logic [rgree_pkg::NUM_W-1:0]       num_q, tmp_q;
  logic [rgree_pkg::DIVS_W-1:0]      nn_q;
  logic [rgree_pkg::TOT_W-1:0]       rgch_q;
  logic [rgree_pkg::REE_W-1:0]       reech_q;
  logic [rgree_pkg::MEAN_W-1:0]      mrg_q, mree_q;
  logic [rgree_pkg::ROOT_W-1:0]      srg_q, sree_q;
  logic                              ov_q;
  logic [rgree_pkg::CNT_W-1:0]       o_ct_q;
  logic [rgree_pkg::MEAN_W-1:0]      o_mrg_q, o_mree_q;
  logic [rgree_pkg::ROOT_W-1:0]      o_srg_q, o_sree_q;

  logic                              acc;
  logic                              out_load;
  logic signed [CW-1:0]              pin [3];
  logic [rgree_pkg::SQ_IN_W-1:0]     sq_in;
  logic [rgree_pkg::SQ_OUT_W-1:0]    sq_out;
  rgree_pkg::ser_req_t               req;
  logic [rgree_pkg::NUM_W-1:0]       opa, ser_res;
  logic [rgree_pkg::OPB_W-1:0]       opb;
  logic                              ser_done;
  logic [rgree_pkg::SUM_W-1:0]       smag;
  logic signed [rgree_pkg::SQ_IN_W-1:0] dree;
  logic [rgree_pkg::MEAN_W-1:0]      qsat;

  function automatic logic [rgree_pkg::SQ_IN_W-1:0] mag25(
    input logic signed [rgree_pkg::SQ_IN_W-1:0] v);
    return v[rgree_pkg::SQ_IN_W-1] ? rgree_pkg::SQ_IN_W'(-v) : rgree_pkg::SQ_IN_W'(v);
  endfunction

  function automatic logic [rgree_pkg::TOT_W-1:0] sat_add(
    input logic [rgree_pkg::TOT_W-1:0] a, input logic [rgree_pkg::TOT_W-1:0] b);
    logic [rgree_pkg::TOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[rgree_pkg::TOT_W] ? {rgree_pkg::TOT_W{1'b1}} : s[rgree_pkg::TOT_W-1:0];
  endfunction

  assign pin[0] = in_i.pos_x;
  assign pin[1] = in_i.pos_y;
  assign pin[2] = in_i.pos_z;

  assign acc      = in_i.valid && in_i.ready;
  assign out_load = (state_q == rgree_pkg::ST_OUT) && (!ov_q || out_o.ready);
  assign axs      = (ax_q == 2'd3) ? 2'd0 : ax_q;
  assign axp      = 2'(ax_q - 2'd1);
  assign smag     = csum_q[axs][rgree_pkg::SUM_W-1] ?
                    rgree_pkg::SUM_W'(-csum_q[axs]) : rgree_pkg::SUM_W'(csum_q[axs]);
  assign dree     = rgree_pkg::SQ_IN_W'(p_q[axs]) - rgree_pkg::SQ_IN_W'(first_q[axs]);
  assign qsat     = (|ser_res[rgree_pkg::NUM_W-1:rgree_pkg::MEAN_W]) ?
                    rgree_pkg::MEAN_MAX : ser_res[rgree_pkg::MEAN_W-1:0];

  rgree_sq u_sq (
    .clk_i (clk_i),
    .a_i   (sq_in),
    .p_o   (sq_out)
  );

  rgree_ser u_ser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (opa),
    .b_i    (opb),
    .done_o (ser_done),
    .res_o  (ser_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rgree_pkg::ST_IDLE:     if (acc) state_d = rgree_pkg::ST_ATOM;
      rgree_pkg::ST_ATOM: begin
        if (ax_q == 2'd3) begin
          if (!(ce_q || fe_q))                state_d = rgree_pkg::ST_IDLE;
          else if (cc_q < rgree_pkg::MAX_CHAINS) state_d = rgree_pkg::ST_REE;
          else                                 state_d = rgree_pkg::ST_CLOSE;
        end
      end
      rgree_pkg::ST_REE:      if (ax_q == 2'd3) state_d = rgree_pkg::ST_NSQ;
      rgree_pkg::ST_NSQ:      state_d = rgree_pkg::ST_NSQW;
      rgree_pkg::ST_NSQW:     state_d = rgree_pkg::ST_AXIS;
      rgree_pkg::ST_AXIS: begin
        if (ax_q == 2'd3) begin
          state_d = (cnt_q != '0) ? rgree_pkg::ST_DIV_RG : rgree_pkg::ST_CLOSE;
        end else if (mask_q[axs]) begin
          state_d = rgree_pkg::ST_MUL_A;
        end
      end
      rgree_pkg::ST_MUL_A:    if (ser_done) state_d = rgree_pkg::ST_MUL_B;
      rgree_pkg::ST_MUL_B:    if (ser_done) state_d = rgree_pkg::ST_AXIS;
      rgree_pkg::ST_DIV_RG:   if (ser_done) state_d = rgree_pkg::ST_CLOSE;
      rgree_pkg::ST_CLOSE:    state_d = fe_q ? rgree_pkg::ST_DIV_MRG : rgree_pkg::ST_IDLE;
      rgree_pkg::ST_DIV_MRG:  if (ser_done) state_d = rgree_pkg::ST_DIV_MREE;
      rgree_pkg::ST_DIV_MREE: if (ser_done) state_d = rgree_pkg::ST_SQ_RG;
      rgree_pkg::ST_SQ_RG:    if (ser_done) state_d = rgree_pkg::ST_SQ_REE;
      rgree_pkg::ST_SQ_REE:   if (ser_done) state_d = rgree_pkg::ST_OUT;
      rgree_pkg::ST_OUT:      if (out_load) state_d = rgree_pkg::ST_IDLE;
      default:                state_d = rgree_pkg::ST_IDLE;
    endcase
  end

  // unit controls and operands
  always_comb begin
    req.start = 1'b0;
    req.op    = rgree_pkg::OP_MUL;
    opa       = '0;
    opb       = '0;
    sq_in     = '0;
    case (state_q)
      rgree_pkg::ST_ATOM: sq_in = mag25(rgree_pkg::SQ_IN_W'(p_q[axs]));
      rgree_pkg::ST_REE:  sq_in = mag25(dree);
      rgree_pkg::ST_NSQ:  sq_in = rgree_pkg::SQ_IN_W'(cnt_q);
      rgree_pkg::ST_MUL_A: begin
        req.start = 1'b1;
        opa       = rgree_pkg::NUM_W'(ssum_q[axs]);
        opb       = rgree_pkg::OPB_W'(cnt_q);
      end
      rgree_pkg::ST_MUL_B: begin
        req.start = 1'b1;
        opa       = rgree_pkg::NUM_W'(smag);
        opb       = rgree_pkg::OPB_W'(smag);
      end
      rgree_pkg::ST_DIV_RG: begin
        req.start = 1'b1;
        req.op    = rgree_pkg::OP_DIV;
        opa       = num_q;
        opb       = rgree_pkg::OPB_W'(nn_q);
      end
      rgree_pkg::ST_DIV_MRG: begin
        req.start = 1'b1;
        req.op    = rgree_pkg::OP_DIV;
        opa       = rgree_pkg::NUM_W'(rgt_q);
        opb       = rgree_pkg::OPB_W'(cc_q);
      end
      rgree_pkg::ST_DIV_MREE: begin
        req.start = 1'b1;
        req.op    = rgree_pkg::OP_DIV;
        opa       = rgree_pkg::NUM_W'(reet_q);
        opb       = rgree_pkg::OPB_W'(cc_q);
      end
      rgree_pkg::ST_SQ_RG: begin
        req.start = 1'b1;
        req.op    = rgree_pkg::OP_SQRT;
        opa       = rgree_pkg::NUM_W'(mrg_q);
      end
      rgree_pkg::ST_SQ_REE: begin
        req.start = 1'b1;
        req.op    = rgree_pkg::OP_SQRT;
        opa       = rgree_pkg::NUM_W'(mree_q);
      end
      default: begin
        sq_in = '0;
      end
    endcase
  end

  // control and accumulated state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rgree_pkg::ST_IDLE;
      ax_q    <= '0;
      mask_q  <= rgree_pkg::MASK_RESET;
      cnt_q   <= '0;
      cc_q    <= '0;
      rgt_q   <= '0;
      reet_q  <= '0;
      ov_q    <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        first_q[a] <= '0;
        csum_q[a]  <= '0;
        ssum_q[a]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) mask_q <= cfg_wdata_i;
      if (out_load)                      ov_q <= 1'b1;
      else if (out_o.ready)              ov_q <= 1'b0;
      case (state_q)
        rgree_pkg::ST_IDLE: begin
          ax_q <= '0;
          if (acc) begin
            for (int a = 0; a < 3; a++) begin
              if (cnt_q == '0) first_q[a] <= pin[a];
              if (cnt_q < rgree_pkg::MAX_CHAIN_ATOMS) begin
                csum_q[a] <= csum_q[a] + rgree_pkg::SUM_W'(pin[a]);
              end
            end
            if (cnt_q < rgree_pkg::MAX_CHAIN_ATOMS) cnt_q <= cnt_q + 17'd1;
          end
        end
        rgree_pkg::ST_ATOM: begin
          ax_q <= 2'(ax_q + 2'd1);
          if (ax_q != 2'd0 && add_q) begin
            ssum_q[axp] <= ssum_q[axp] + rgree_pkg::SQS_W'(sq_out);
          end
        end
        rgree_pkg::ST_REE:  ax_q <= 2'(ax_q + 2'd1);
        rgree_pkg::ST_NSQW: ax_q <= '0;
        rgree_pkg::ST_AXIS: begin
          if (ax_q != 2'd3 && !mask_q[axs]) ax_q <= 2'(ax_q + 2'd1);
        end
        rgree_pkg::ST_MUL_B: if (ser_done) ax_q <= 2'(ax_q + 2'd1);
        rgree_pkg::ST_CLOSE: begin
          if (cc_q < rgree_pkg::MAX_CHAINS) begin
            rgt_q  <= sat_add(rgt_q, rgch_q);
            reet_q <= sat_add(reet_q, rgree_pkg::TOT_W'(reech_q));
            cc_q   <= cc_q + 17'd1;
          end
          cnt_q <= '0;
          for (int a = 0; a < 3; a++) begin
            first_q[a] <= '0;
            csum_q[a]  <= '0;
            ssum_q[a]  <= '0;
          end
        end
        rgree_pkg::ST_OUT: begin
          if (out_load) begin
            rgt_q  <= '0;
            reet_q <= '0;
            cc_q   <= '0;
          end
        end
        default: begin
          ax_q <= ax_q;
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      rgree_pkg::ST_IDLE: begin
        if (acc) begin
          for (int a = 0; a < 3; a++) p_q[a] <= pin[a];
          ce_q  <= in_i.chain_end;
          fe_q  <= in_i.frm_end;
          add_q <= cnt_q < rgree_pkg::MAX_CHAIN_ATOMS;
        end
      end
      rgree_pkg::ST_ATOM: begin
        reech_q <= '0;
        rgch_q  <= '0;
      end
      rgree_pkg::ST_REE: begin
        if (ax_q != 2'd0 && mask_q[axp]) reech_q <= reech_q + rgree_pkg::REE_W'(sq_out);
      end
      rgree_pkg::ST_NSQW: begin
        nn_q  <= sq_out[rgree_pkg::DIVS_W-1:0];
        num_q <= '0;
      end
      rgree_pkg::ST_MUL_A:    if (ser_done) tmp_q <= ser_res;
      rgree_pkg::ST_MUL_B:    if (ser_done) num_q <= num_q + (tmp_q - ser_res);
      rgree_pkg::ST_DIV_RG:   if (ser_done) rgch_q <= ser_res[rgree_pkg::TOT_W-1:0];
      rgree_pkg::ST_DIV_MRG:  if (ser_done) mrg_q <= qsat;
      rgree_pkg::ST_DIV_MREE: if (ser_done) mree_q <= qsat;
      rgree_pkg::ST_SQ_RG:    if (ser_done) srg_q <= ser_res[rgree_pkg::ROOT_W-1:0];
      rgree_pkg::ST_SQ_REE:   if (ser_done) sree_q <= ser_res[rgree_pkg::ROOT_W-1:0];
      rgree_pkg::ST_OUT: begin
        if (out_load) begin
          o_ct_q   <= cc_q;
          o_mrg_q  <= mrg_q;
          o_srg_q  <= srg_q;
          o_mree_q <= mree_q;
          o_sree_q <= sree_q;
        end
      end
      default: begin
        tmp_q <= tmp_q;
      end
    endcase
  end

  assign in_i.ready        = (state_q == rgree_pkg::ST_IDLE);
  assign out_o.valid       = ov_q;
  assign out_o.chain_total = o_ct_q;
  assign out_o.mean_rg_sq  = o_mrg_q;
  assign out_o.mean_rg     = o_srg_q;
  assign out_o.mean_e2e_sq = o_mree_q;
  assign out_o.mean_e2e    = o_sree_q;

endmodule

// ===== sv/rgree_chk.sv =====
// ----------------------------------------------------------------------------
// rgree_chk
// Port-level checks of the accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module rgree_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [rgree_pkg::CNT_W-1:0]       chain_total_i,
  input logic [rgree_pkg::MEAN_W-1:0]      mean_rg_sq_i,
  input logic [rgree_pkg::ROOT_W-1:0]      mean_rg_i,
  input logic [rgree_pkg::MEAN_W-1:0]      mean_e2e_sq_i,
  input logic [rgree_pkg::ROOT_W-1:0]      mean_e2e_i
);

  logic [49:0] rg_lo, rg_hi, ree_lo, ree_hi;

  assign rg_lo  = 50'(mean_rg_i) * 50'(mean_rg_i);
  assign rg_hi  = (50'(mean_rg_i) + 50'd1) * (50'(mean_rg_i) + 50'd1);
  assign ree_lo = 50'(mean_e2e_i) * 50'(mean_e2e_i);
  assign ree_hi = (50'(mean_e2e_i) + 50'd1) * (50'(mean_e2e_i) + 50'd1);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready not dropped after accept");

  a_rg_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> rg_lo <= 50'(mean_rg_sq_i) && rg_hi > 50'(mean_rg_sq_i))
    else $error("mean_rg not floor root");

  a_ree_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ree_lo <= 50'(mean_e2e_sq_i) && ree_hi > 50'(mean_e2e_sq_i))
    else $error("mean_e2e not floor root");

  a_chains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> chain_total_i != '0)
    else $error("result with no chains");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(mean_rg_sq_i))
    else $error("stalled word changed");

endmodule

bind polymer_rg_ree_accumulator_top rgree_chk u_rgree_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .chain_total_i (out_o.chain_total),
  .mean_rg_sq_i  (out_o.mean_rg_sq),
  .mean_rg_i     (out_o.mean_rg),
  .mean_e2e_sq_i (out_o.mean_e2e_sq),
  .mean_e2e_i    (out_o.mean_e2e)
);

// ===== verif/tb_polymer_rg_ree_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// tb_polymer_rg_ree_accumulator_top
// Streams atom words through the Rg / end-to-end accumulator and compares
// every frame result against a local predictor of the per-chain sums,
// frame totals, floor means and floor roots, across several axis masks.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_polymer_rg_ree_accumulator_top;

  localparam int COORD_W = rgree_pkg::COORD_W;
  localparam int CNT_W   = rgree_pkg::CNT_W;
  localparam int SUM_W   = rgree_pkg::SUM_W;
  localparam int SQS_W   = rgree_pkg::SQS_W;
  localparam int TOT_W   = rgree_pkg::TOT_W;
  localparam int MEAN_W  = rgree_pkg::MEAN_W;
  localparam int ROOT_W  = rgree_pkg::ROOT_W;
  localparam int MASK_W  = rgree_pkg::MASK_W;
  localparam logic [MASK_W-1:0] MASK_RESET = rgree_pkg::MASK_RESET;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      ce;
    logic                      fe;
  } atom_t;

  typedef struct packed {
    logic [CNT_W-1:0]  chains;
    logic [MEAN_W-1:0] rg_sq;
    logic [ROOT_W-1:0] rg;
    logic [MEAN_W-1:0] ree_sq;
    logic [ROOT_W-1:0] ree;
  } frame_res_t;

  typedef struct {
    atom_t      a;
    logic       has_res;
    frame_res_t res;
  } dir_row_t;

  localparam int STALL_LIMIT = 20000;
  localparam logic [MEAN_W-1:0] M48 = {MEAN_W{1'b1}};

  logic clk_i, rst_ni, cfg_we_i;
  logic [MASK_W-1:0] cfg_wdata_i;

  rgree_in_if  in_ch ();
  rgree_out_if out_ch ();

  polymer_rg_ree_accumulator_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  logic [MASK_W-1:0]       mask_q;
  longint unsigned         n_atoms;
  logic signed [SUM_W-1:0] csum [3];
  logic [SQS_W-1:0]        sqsum [3];
  logic signed [COORD_W-1:0] first_pos [3];
  logic [TOT_W-1:0]        rg_tot, ree_tot;
  longint unsigned         chain_cnt;

  frame_res_t frame_q [$];
  int errors, n_words, n_frames, idle_cnt;
  logic done;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("error: frame %0d %s got %0h exp %0h", n_frames, what, got, exp);
    errors++;
  endtask

  function automatic logic [ROOT_W-1:0] floor_root(input logic [MEAN_W-1:0] v);
    logic [ROOT_W-1:0] r;
    logic [ROOT_W-1:0] t;
    r = '0;
    for (int b = ROOT_W-1; b >= 0; b--) begin
      t = r | (ROOT_W'(1) << b);
      if (64'(t) * 64'(t) <= 64'(v)) r = t;
    end
    return r;
  endfunction

  function automatic logic [TOT_W-1:0] sat_sum(input logic [TOT_W-1:0] a, input logic [TOT_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
  endfunction

  function automatic void clear_chain_sums();
    n_atoms = 0;
    for (int k = 0; k < 3; k++) begin
      csum[k] = '0; sqsum[k] = '0; first_pos[k] = '0;
    end
  endfunction

  task automatic predict_word(input atom_t a);
    logic signed [COORD_W-1:0] p [3];
    logic [127:0] num, t1, t2;
    logic [63:0] ree, rg, ab;
    logic signed [63:0] d;
    logic [63:0] mrg, mree;
    frame_res_t r;
    p[0] = a.x; p[1] = a.y; p[2] = a.z;
    if (n_atoms == 0) for (int k = 0; k < 3; k++) first_pos[k] = p[k];
    if (n_atoms < 65536) begin
      n_atoms++;
      for (int k = 0; k < 3; k++) begin
        csum[k] += SUM_W'(p[k]);
        sqsum[k] += 64'(64'(signed'(p[k])) * 64'(signed'(p[k])));
      end
    end
    if (a.ce || a.fe) begin
      if (chain_cnt < 65536) begin
        num = '0; ree = '0;
        for (int k = 0; k < 3; k++) if (mask_q[k]) begin
          t1 = 128'(n_atoms) * 128'(sqsum[k]);
          ab = csum[k] < 0 ? 64'(-64'(csum[k])) : 64'(csum[k]);
          t2 = 128'(ab) * 128'(ab);
          num += t1 - t2;
          d = 64'(signed'(p[k])) - 64'(signed'(first_pos[k]));
          ab = d < 0 ? 64'(-d) : 64'(d);
          ree += ab * ab;
        end
        rg = n_atoms != 0 ? 64'(num / (128'(n_atoms) * 128'(n_atoms))) : 64'd0;
        rg_tot = sat_sum(rg_tot, rg);
        ree_tot = sat_sum(ree_tot, ree);
        chain_cnt++;
      end
      clear_chain_sums();
    end
    if (a.fe) begin
      mrg = chain_cnt != 0 ? rg_tot / chain_cnt : 0;
      mree = chain_cnt != 0 ? ree_tot / chain_cnt : 0;
      if (mrg > 64'(M48)) mrg = 64'(M48);
      if (mree > 64'(M48)) mree = 64'(M48);
      r.chains = CNT_W'(chain_cnt);
      r.rg_sq = mrg[MEAN_W-1:0];
      r.rg = floor_root(mrg[MEAN_W-1:0]);
      r.ree_sq = mree[MEAN_W-1:0];
      r.ree = floor_root(mree[MEAN_W-1:0]);
      frame_q.insert(frame_q.size(), r);
      rg_tot = '0; ree_tot = '0; chain_cnt = 0;
    end
  endtask

  // sender with bursts and gaps
  task automatic send_word(input atom_t a);
    in_ch.valid <= 1'b1;
    {in_ch.pos_x, in_ch.pos_y, in_ch.pos_z, in_ch.chain_end, in_ch.frm_end} <= a;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_word(a);
    n_words++;
    @(negedge clk_i);
    if ($urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic drain_and_cfg(input logic [MASK_W-1:0] m);
    in_ch.valid <= 1'b0;
    while (frame_q.size() != 0) @(negedge clk_i);
    repeat (800) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mask_q = m;
  endtask

  function automatic logic signed [COORD_W-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return COORD_W'($urandom_range(0, 200)) - 24'sd100;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic atom_t rnd_atom(input logic ce, input logic fe);
    atom_t a;
    a.x = rnd_coord(); a.y = rnd_coord(); a.z = rnd_coord();
    a.ce = ce; a.fe = fe;
    return a;
  endfunction

  // receiver stall pattern and checking
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ch.ready <= ($urandom_range(0, 15) < 4) ? 1'b0 : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (frame_q.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        frame_res_t e;
        e = frame_q.pop_front();
        if (out_ch.chain_total !== e.chains) report("chain_total", out_ch.chain_total, e.chains);
        if (out_ch.mean_rg_sq !== e.rg_sq) report("mean_rg_sq", out_ch.mean_rg_sq, e.rg_sq);
        if (out_ch.mean_rg !== e.rg) report("mean_rg", out_ch.mean_rg, e.rg);
        if (out_ch.mean_e2e_sq !== e.ree_sq) report("mean_e2e_sq", out_ch.mean_e2e_sq, e.ree_sq);
        if (out_ch.mean_e2e !== e.ree) report("mean_e2e", out_ch.mean_e2e, e.ree);
        n_frames++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni || done)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("watchdog: no progress in %0d cycles", STALL_LIMIT);
      $display("polymer_rg_ree_accumulator_top: mismatch");
      $finish;
    end
  end

  initial begin
    dir_row_t rows [$];
    dir_row_t r;
    logic [MASK_W-1:0] masks [5];
    atom_t a;
    int len, nch;
    masks = '{3'd1, 3'd0, 3'd6, 3'd2, 3'd7};
    errors = 0; n_words = 0; n_frames = 0; idle_cnt = 0; done = 1'b0;
    cfg_we_i = 1'b0; cfg_wdata_i = MASK_RESET;
    in_ch.valid = 1'b0; in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
    in_ch.chain_end = 1'b0; in_ch.frm_end = 1'b0;
    mask_q = MASK_RESET; rg_tot = '0; ree_tot = '0; chain_cnt = 0;
    clear_chain_sums();
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: single-atom frame gives zeros; extremes; frame end without chain end
    r.has_res = 1'b1; r.res = '{CNT_W'(1), '0, '0, '0, '0};
    r.a = '{24'sd5, -24'sd7, 24'sd9, 1'b1, 1'b1}; rows.insert(rows.size(), r);
    r.has_res = 1'b1; r.res = '{CNT_W'(1), '0, '0, '0, '0};
    r.a = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 1'b0, 1'b1}; rows.insert(rows.size(), r);
    r.has_res = 1'b0;
    r.a = '{24'sh800000, 24'sh800000, 24'sh800000, 1'b0, 1'b0}; rows.insert(rows.size(), r);
    r.a = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1, 1'b0}; rows.insert(rows.size(), r);
    r.a = '{24'sh7FFFFF, 24'sh800000, 24'sd0, 1'b0, 1'b0}; rows.insert(rows.size(), r);
    r.a = '{24'sh800000, 24'sh7FFFFF, -24'sd1, 1'b0, 1'b0}; rows.insert(rows.size(), r);
    r.a = '{24'sd4096, 24'sd0, 24'sh7FFFFF, 1'b0, 1'b1}; rows.insert(rows.size(), r);
    r.a = '{24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b0}; rows.insert(rows.size(), r);
    r.a = '{24'sd1, 24'sd2, 24'sd3, 1'b1, 1'b1}; rows.insert(rows.size(), r);
    @(negedge clk_i);
    foreach (rows[i]) begin
      send_word(rows[i].a);
      if (rows[i].has_res && frame_q[$] !== rows[i].res)
        report("directed expectation", 64'(i), 0);
    end

    // random, one phase per mask
    foreach (masks[m]) begin
      drain_and_cfg(masks[m]);
      while (n_words < 9 + 80 * (m + 1)) begin
        nch = $urandom_range(1, 4);
        for (int c = 0; c < nch; c++) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
          for (int k = 0; k < len; k++) begin
            a = rnd_atom(k == len - 1, (c == nch - 1) && (k == len - 1));
            if (a.fe && $urandom_range(0, 3) == 0) a.ce = 1'b0;
            send_word(a);
          end
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (frame_q.size() != 0) @(negedge clk_i);
    done = 1'b1;
    repeat (500) @(negedge clk_i);
    $display("sent %0d atom words, checked %0d frame results over 6 mask phases",
             n_words, n_frames);
    if (errors == 0)
      $display("polymer_rg_ree_accumulator_top: match");
    else
      $display("polymer_rg_ree_accumulator_top: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rgree_pkg.sv
sv/rgree_in_if.sv
sv/rgree_out_if.sv
sv/rgree_sq.sv
sv/rgree_ser.sv
sv/polymer_rg_ree_accumulator_top.sv
sv/rgree_chk.sv
verif/tb_polymer_rg_ree_accumulator_top.sv
